@@ src/zfhd_pkg.sv @@
`default_nettype none
package zfhd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CodeW = 16;
	localparam int unsigned FlagW = 4;

	typedef enum logic [2:0] {
		PH_CTRL = 3'd0,
		PH_MLO  = 3'd1,
		PH_MHI  = 3'd2,
		PH_SEQ  = 3'd3,
		PH_CMD  = 3'd4,
		PH_PAY  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] data_byte;
		logic             frame_end;
	} item_t;

	typedef struct packed {
		logic             is_header;
		logic             cluster_specific;
		logic             manufacturer_flag;
		logic             server_to_client;
		logic             no_default_response;
		logic [CodeW-1:0] manufacturer_code;
		logic [ByteW-1:0] sequence_number;
		logic [ByteW-1:0] command_id;
		logic [ByteW-1:0] payload_byte;
		logic             frame_done;
		logic             truncated;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t res;
	} step_t;

	function automatic result_t header(logic [FlagW-1:0] flags, logic [CodeW-1:0] code,
		logic [ByteW-1:0] seq, logic [ByteW-1:0] cmd, logic done, logic trunc);
		result_t r;
		r.is_header           = 1'b1;
		r.cluster_specific    = flags[0];
		r.manufacturer_flag   = flags[1];
		r.server_to_client    = flags[2];
		r.no_default_response = flags[3];
		r.manufacturer_code   = code;
		r.sequence_number     = seq;
		r.command_id          = cmd;
		r.payload_byte        = '0;
		r.frame_done          = done;
		r.truncated           = trunc;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/zfhd_parse.sv @@
`default_nettype none
module zfhd_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire zfhd_pkg::item_t beat,
	output zfhd_pkg::step_t    step
);

	zfhd_pkg::phase_t                   phase_q, phase_d;
	logic [zfhd_pkg::FlagW-1:0]         flags_q, flags_d, flags_new;
	logic [zfhd_pkg::CodeW-1:0]         code_q, code_d;
	logic [zfhd_pkg::ByteW-1:0]         seq_q, seq_d;
	logic [zfhd_pkg::ByteW-1:0]         b;
	logic                               last;

	assign b         = beat.data_byte;
	assign last      = beat.frame_end;
	assign flags_new = {b[4], b[3], b[2], b[0]};

	always_comb begin
		phase_d = phase_q;
		flags_d = flags_q;
		code_d  = code_q;
		seq_d   = seq_q;
		unique case (phase_q)
			zfhd_pkg::PH_MLO: begin
				code_d  = {{(zfhd_pkg::CodeW-zfhd_pkg::ByteW){1'b0}}, b};
				phase_d = zfhd_pkg::PH_MHI;
			end
			zfhd_pkg::PH_MHI: begin
				code_d  = {b, code_q[zfhd_pkg::ByteW-1:0]};
				phase_d = zfhd_pkg::PH_SEQ;
			end
			zfhd_pkg::PH_SEQ: begin
				seq_d   = b;
				phase_d = zfhd_pkg::PH_CMD;
			end
			zfhd_pkg::PH_CMD: begin
				phase_d = zfhd_pkg::PH_PAY;
			end
			zfhd_pkg::PH_PAY: begin
				phase_d = zfhd_pkg::PH_PAY;
			end
			default: begin
				flags_d = flags_new;
				code_d  = '0;
				seq_d   = '0;
				phase_d = flags_new[1] ? zfhd_pkg::PH_MLO : zfhd_pkg::PH_SEQ;
			end
		endcase
		if (last) begin
			phase_d = zfhd_pkg::PH_CTRL;
			flags_d = '0;
			code_d  = '0;
			seq_d   = '0;
		end
	end

	always_comb begin
		step.emit = 1'b0;
		step.res  = '0;
		unique case (phase_q)
			zfhd_pkg::PH_MLO: begin
				step.emit = last;
				step.res  = zfhd_pkg::header(flags_q, '0, '0, '0, 1'b1, 1'b1);
			end
			zfhd_pkg::PH_MHI: begin
				step.emit = last;
				step.res  = zfhd_pkg::header(flags_q, {b, code_q[zfhd_pkg::ByteW-1:0]},
					'0, '0, 1'b1, 1'b1);
			end
			zfhd_pkg::PH_SEQ: begin
				step.emit = last;
				step.res  = zfhd_pkg::header(flags_q, code_q, b, '0, 1'b1, 1'b1);
			end
			zfhd_pkg::PH_CMD: begin
				step.emit = 1'b1;
				step.res  = zfhd_pkg::header(flags_q, code_q, seq_q, b, last, 1'b0);
			end
			zfhd_pkg::PH_PAY: begin
				step.emit             = 1'b1;
				step.res.payload_byte = b;
				step.res.frame_done   = last;
			end
			default: begin
				step.emit = last;
				step.res  = zfhd_pkg::header(flags_new, '0, '0, '0, 1'b1, 1'b1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= zfhd_pkg::PH_CTRL;
			flags_q <= '0;
			code_q  <= '0;
			seq_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			code_q  <= code_d;
			seq_q   <= seq_d;
		end
	end

endmodule
`default_nettype wire

@@ src/zcl_frame_header_deframer_top.sv @@
// Cluster-library frame header deframer.
// Input channel item_valid / item_ready / item carries one frame byte per
// beat with a frame_end mark on the last byte of each frame.
// Output channel result_valid / result_ready / result carries header and
// payload results. Header bytes produce nothing until the command byte,
// which produces one header result; every later byte produces one payload
// result. A frame that ends inside its header produces one header result
// with truncated set and the missing fields zero.
// A beat accepted on the input channel is registered in the input stage,
// decoded, and registered into the output result register once that
// register is free.
// Throughput: one beat per cycle while the result register is free or the
// beat yields no result; the phase update sits between the two registers.
// Reset clears both stage valids and returns the parser to expecting a
// frame control byte; no clearing pass follows.
// When the receiver stalls, the result is held and the input stage still
// drains beats that produce no result; a beat that would produce one waits
// in the input stage and item_ready drops once that stage is occupied.
`default_nettype none
module zcl_frame_header_deframer_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire zfhd_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output zfhd_pkg::result_t      result
);

	logic              valid_s1;
	zfhd_pkg::item_t   item_s1;
	logic              valid_s2;
	zfhd_pkg::result_t result_s2;
	zfhd_pkg::step_t   step;
	logic              s2_free;
	logic              fire_s1;

	assign s2_free    = !valid_s2 || result_ready;
	assign fire_s1    = valid_s1 && (!step.emit || s2_free);
	assign item_ready = !valid_s1 || fire_s1;

	zfhd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (fire_s1),
		.beat    (item_s1),
		.step    (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (s2_free) begin
				valid_s2 <= fire_s1 && step.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (s2_free && fire_s1 && step.emit) begin
			result_s2 <= step.res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	a_trunc_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.truncated |-> result_s2.is_header && result_s2.frame_done)
		else $error("truncated result does not end a frame");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.is_header |->
		result_s2.manufacturer_code == '0 && result_s2.command_id == '0 &&
		result_s2.sequence_number == '0 && !result_s2.truncated)
		else $error("payload result carries header fields");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire_s1 |=> valid_s1 && $stable(item_s1))
		else $error("stalled input stage lost its beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_ready |=> valid_s2 && $stable(result_s2))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

@@ tb/zcl_frame_header_deframer_top_tb.sv @@
`timescale 1ns / 1ps
module zcl_frame_header_deframer_top_tb;
	import zfhd_pkg::*;

	localparam int unsigned IdleLimit = 4000;
	localparam int unsigned DrainCycles = 10;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	bit      row_typed = 1'b0;
	result_t row_want = '0;

	int unsigned send_idle_pct;
	int unsigned stall_pct = 0;
	int unsigned beats_sent;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;

	phase_t           hdr_phase;
	logic [FlagW-1:0] hdr_flags;
	logic [CodeW-1:0] hdr_code;
	logic [ByteW-1:0] hdr_seq;

	result_t expected_results [$];

	zcl_frame_header_deframer_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t header_result(logic [FlagW-1:0] f, logic [CodeW-1:0] code,
		logic [ByteW-1:0] seq, logic [ByteW-1:0] cmd, logic done, logic trunc);
		result_t r;
		r = '0;
		r.is_header           = 1'b1;
		r.cluster_specific    = f[0];
		r.manufacturer_flag   = f[1];
		r.server_to_client    = f[2];
		r.no_default_response = f[3];
		r.manufacturer_code   = code;
		r.sequence_number     = seq;
		r.command_id          = cmd;
		r.frame_done          = done;
		r.truncated           = trunc;
		return r;
	endfunction

	task automatic restart_header();
		hdr_phase = PH_CTRL;
		hdr_flags = '0;
		hdr_code  = '0;
		hdr_seq   = '0;
	endtask

	task automatic parse_byte(input item_t it, output bit emit, output result_t r);
		logic [ByteW-1:0] b;
		logic             last;
		b    = it.data_byte;
		last = it.frame_end;
		emit = 1'b0;
		r    = '0;
		case (hdr_phase)
			PH_MLO: begin
				hdr_code = {8'h00, b};
				if (last) begin
					emit = 1'b1;
					r = header_result(hdr_flags, '0, '0, '0, 1'b1, 1'b1);
					restart_header();
				end else begin
					hdr_phase = PH_MHI;
				end
			end
			PH_MHI: begin
				hdr_code = {b, hdr_code[7:0]};
				if (last) begin
					emit = 1'b1;
					r = header_result(hdr_flags, hdr_code, '0, '0, 1'b1, 1'b1);
					restart_header();
				end else begin
					hdr_phase = PH_SEQ;
				end
			end
			PH_SEQ: begin
				hdr_seq = b;
				if (last) begin
					emit = 1'b1;
					r = header_result(hdr_flags, hdr_code, hdr_seq, '0, 1'b1, 1'b1);
					restart_header();
				end else begin
					hdr_phase = PH_CMD;
				end
			end
			PH_CMD: begin
				emit = 1'b1;
				r = header_result(hdr_flags, hdr_code, hdr_seq, b, last, 1'b0);
				if (last)
					restart_header();
				else
					hdr_phase = PH_PAY;
			end
			PH_PAY: begin
				emit = 1'b1;
				r.payload_byte = b;
				r.frame_done   = last;
				if (last)
					restart_header();
			end
			default: begin
				hdr_flags = {b[4], b[3], b[2], b[0]};
				hdr_code  = '0;
				hdr_seq   = '0;
				if (last) begin
					emit = 1'b1;
					r = header_result(hdr_flags, '0, '0, '0, 1'b1, 1'b1);
					restart_header();
				end else begin
					hdr_phase = hdr_flags[1] ? PH_MLO : PH_SEQ;
				end
			end
		endcase
	endtask

	function automatic bit results_match(result_t a, result_t b);
		return a.is_header == b.is_header &&
			a.cluster_specific == b.cluster_specific &&
			a.manufacturer_flag == b.manufacturer_flag &&
			a.server_to_client == b.server_to_client &&
			a.no_default_response == b.no_default_response &&
			a.manufacturer_code == b.manufacturer_code &&
			a.sequence_number == b.sequence_number &&
			a.command_id == b.command_id &&
			a.payload_byte == b.payload_byte &&
			a.frame_done == b.frame_done &&
			a.truncated == b.truncated;
	endfunction

	function automatic stim_row_t plain_row(logic [ByteW-1:0] b, logic last);
		stim_row_t s;
		s.it.data_byte = b;
		s.it.frame_end = last;
		s.typed        = 1'b0;
		s.want         = '0;
		return s;
	endfunction

	function automatic stim_row_t known_row(logic [ByteW-1:0] b, logic last, result_t w);
		stim_row_t s;
		s       = plain_row(b, last);
		s.typed = 1'b1;
		s.want  = w;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit      emit;
		result_t r;
		result_t want;
		if (!arst_n) begin
			restart_header();
		end else begin
			if (item_valid && item_ready) begin
				parse_byte(item, emit, r);
				if (row_typed)
					expected_results.push_back(row_want);
				else if (emit)
					expected_results.push_back(r);
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", result);
				end else begin
					want = expected_results.pop_front();
					if (!results_match(want, result)) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %h got %h", want, result);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IdleLimit) begin
			$display("FAIL zcl_frame_header_deframer_top");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_beat(input item_t it, input bit typed, input result_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= it;
		row_typed  <= typed;
		row_want   <= want;
		do @(posedge clk); while (!item_ready);
		beats_sent++;
	endtask

	task automatic send_random_frame();
		logic [ByteW-1:0] fb [16];
		item_t it;
		int    n;
		int    hdr_len;
		int    pick;
		for (int k = 0; k < 16; k++)
			fb[k] = 8'($urandom);
		hdr_len = fb[0][2] ? 5 : 3;
		pick = $urandom_range(99);
		if (pick < 75)
			n = hdr_len + $urandom_range(6);
		else if (pick < 90)
			n = $urandom_range(hdr_len - 1, 1);
		else
			n = $urandom_range(4, 1);
		for (int k = 0; k < n; k++) begin
			it.data_byte = fb[k];
			it.frame_end = (pick < 90) ? (k == n - 1) : 1'($urandom_range(1));
			send_beat(it, 1'b0, '0);
		end
	endtask

	task automatic hold_until_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	initial begin
		stim_row_t dir_rows [$];
		send_idle_pct = 0;
		beats_sent    = 0;

		dir_rows.push_back(known_row(8'hFF, 1'b1,
			header_result(4'hF, '0, '0, '0, 1'b1, 1'b1)));
		dir_rows.push_back(known_row(8'h00, 1'b1,
			header_result(4'h0, '0, '0, '0, 1'b1, 1'b1)));
		dir_rows.push_back(plain_row(8'h04, 1'b0));
		dir_rows.push_back(plain_row(8'hFF, 1'b0));
		dir_rows.push_back(plain_row(8'hFF, 1'b0));
		dir_rows.push_back(plain_row(8'hFF, 1'b0));
		dir_rows.push_back(plain_row(8'hFF, 1'b0));
		dir_rows.push_back(plain_row(8'h00, 1'b0));
		dir_rows.push_back(plain_row(8'hFF, 1'b1));
		dir_rows.push_back(plain_row(8'h05, 1'b0));
		dir_rows.push_back(known_row(8'h12, 1'b1,
			header_result(4'b0011, '0, '0, '0, 1'b1, 1'b1)));
		dir_rows.push_back(plain_row(8'h04, 1'b0));
		dir_rows.push_back(plain_row(8'h34, 1'b0));
		dir_rows.push_back(known_row(8'h12, 1'b1,
			header_result(4'b0010, 16'h1234, '0, '0, 1'b1, 1'b1)));
		dir_rows.push_back(plain_row(8'h18, 1'b0));
		dir_rows.push_back(known_row(8'h77, 1'b1,
			header_result(4'b1100, '0, 8'h77, '0, 1'b1, 1'b1)));
		dir_rows.push_back(plain_row(8'h01, 1'b0));
		dir_rows.push_back(plain_row(8'h00, 1'b0));
		dir_rows.push_back(plain_row(8'hAB, 1'b1));
		dir_rows.push_back(plain_row(8'hEA, 1'b0));
		dir_rows.push_back(plain_row(8'h10, 1'b0));
		dir_rows.push_back(plain_row(8'h20, 1'b0));
		dir_rows.push_back(plain_row(8'h55, 1'b0));
		dir_rows.push_back(plain_row(8'hAA, 1'b1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		while (beats_sent < 240)
			send_random_frame();

		send_idle_pct = 82;
		while (beats_sent < 360)
			send_random_frame();
		hold_until_drained();
		while (beats_sent < 480)
			send_random_frame();

		send_idle_pct = 0;
		stall_pct <= 82;
		while (beats_sent < 720)
			send_random_frame();

		send_idle_pct = 30;
		stall_pct <= 30;
		while (beats_sent < 950)
			send_random_frame();

		hold_until_drained();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("PASS zcl_frame_header_deframer_top");
		end else begin
			$display("FAIL zcl_frame_header_deframer_top");
		end
		$finish;
	end

endmodule

@@ zcl_frame_header_deframer_top.f @@
src/zfhd_pkg.sv
src/zfhd_parse.sv
src/zcl_frame_header_deframer_top.sv
tb/zcl_frame_header_deframer_top_tb.sv
